// ===== rtl/core/smrb_pkg.sv =====
// ----------------------------------------------------------------------------
// smrb_pkg - shared types and constants of the sprite blitter
// Register indexes, pivot codes, the quarter sine table and the control structs
// passed to the back end.
// ----------------------------------------------------------------------------
package smrb_pkg;

	localparam int PIX_W       = 32;
	localparam int ADDR_W      = 18;
	localparam int TDATA_OUT_W = 56;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int Q_FRAC      = 14;
	localparam int SIN_W       = 16;

	localparam logic [8:0] DIM_RESET = 9'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANCHOR_X      = 3'd0,
		REG_ANCHOR_Y      = 3'd1,
		REG_ROTATION      = 3'd2,
		REG_PIVOT_SELECT  = 3'd3,
		REG_MIRROR        = 3'd4,
		REG_SPRITE_WIDTH  = 3'd5,
		REG_SPRITE_HEIGHT = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PIV_CENTRE        = 3'd0,
		PIV_CENTRE_LEFT   = 3'd1,
		PIV_CENTRE_RIGHT  = 3'd2,
		PIV_TOP_CENTRE    = 3'd3,
		PIV_BOTTOM_CENTRE = 3'd4,
		PIV_TOP_LEFT      = 3'd5,
		PIV_TOP_RIGHT     = 3'd6
	} pivot_t;

	// rotation controls seen by the back end
	typedef struct packed {
		logic                    rot_zero;
		logic                    mirror;
		logic signed [SIN_W-1:0] sin_v;
		logic signed [SIN_W-1:0] cos_v;
	} trig_t;

	// per-pixel flags set by the front end
	typedef struct packed {
		logic opaque;
		logic done;
	} item_flags_t;

	// round(16384 * sin(d)) for d = 0..90
	localparam logic [14:0] QUARTER_SINE [0:90] = '{
		0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
		2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
		5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
		8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
		10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
		12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
		14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
		15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
		16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
		16384
	};

	// width of the signed screen offsets for a given dimension width
	function automatic int geo_w(input int dw);
		return ((dw > CFG_DATA_W) ? dw : CFG_DATA_W) + 3;
	endfunction

	// sine in Q2.14 of an angle already reduced to 0..359
	function automatic logic signed [SIN_W-1:0] sine_deg(input logic [8:0] d);
		logic [8:0]  idx;
		logic        neg;
		logic [14:0] mag;
		if (d <= 9'd90) begin
			idx = d;
			neg = 1'b0;
		end else if (d <= 9'd180) begin
			idx = 9'd180 - d;
			neg = 1'b0;
		end else if (d <= 9'd270) begin
			idx = d - 9'd180;
			neg = 1'b1;
		end else begin
			idx = 9'd360 - d;
			neg = 1'b1;
		end
		mag = QUARTER_SINE[idx[6:0]];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

endpackage

// ===== rtl/core/smrb_cfg.sv =====
// ----------------------------------------------------------------------------
// smrb_cfg - configuration registers
// Holds the seven registers, clamps the sprite size and registers the values
// derived from them for the back end (sine, cosine, pivot and screen offsets).
// ----------------------------------------------------------------------------
module smrb_cfg #(
	parameter int MAX_SPRITE_DIM = 256,
	localparam int DW = $clog2(MAX_SPRITE_DIM + 1),
	localparam int KW = smrb_pkg::geo_w(DW)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [smrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smrb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [DW-1:0]                    w_eff,
	output logic [DW-1:0]                    h_eff,
	output smrb_pkg::trig_t                  trig_q,
	output logic [DW-1:0]                    mx_q,
	output logic [DW-1:0]                    my_q,
	output logic signed [KW-1:0]             kx_q,
	output logic signed [KW-1:0]             ky_q,
	output logic signed [KW-1:0]             nx_q,
	output logic signed [KW-1:0]             ay_q
);

	localparam int EW = (DW > 9) ? DW : 9;

	logic signed [10:0] anchor_x_q;
	logic signed [10:0] anchor_y_q;
	logic signed [9:0]  rotation_q;
	logic [2:0]         pivot_q;
	logic               mirror_q;
	logic [8:0]         width_q;
	logic [8:0]         height_q;

	logic [EW-1:0]      w_ext, h_ext;
	logic signed [10:0] ang_r;
	logic [8:0]         ang_s;
	logic [9:0]         ang_c_sum;
	logic [8:0]         ang_c;
	logic [DW-1:0]      mx_d, my_d;
	logic signed [KW-1:0] x0, w_s, mx_s, my_s;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			rotation_q <= '0;
			pivot_q    <= '0;
			mirror_q   <= 1'b0;
			width_q    <= smrb_pkg::DIM_RESET;
			height_q   <= smrb_pkg::DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				smrb_pkg::REG_ANCHOR_X:      anchor_x_q <= cfg_data[10:0];
				smrb_pkg::REG_ANCHOR_Y:      anchor_y_q <= cfg_data[10:0];
				smrb_pkg::REG_ROTATION:      rotation_q <= cfg_data[9:0];
				smrb_pkg::REG_PIVOT_SELECT:  pivot_q    <= cfg_data[2:0];
				smrb_pkg::REG_MIRROR:        mirror_q   <= cfg_data[0];
				smrb_pkg::REG_SPRITE_WIDTH:  width_q    <= cfg_data[8:0];
				smrb_pkg::REG_SPRITE_HEIGHT: height_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// zero counts as one, oversize counts as the maximum
	always_comb begin
		w_ext = EW'(width_q);
		h_ext = EW'(height_q);
		if (w_ext == '0)
			w_eff = DW'(1);
		else if (w_ext > EW'(MAX_SPRITE_DIM))
			w_eff = DW'(MAX_SPRITE_DIM);
		else
			w_eff = DW'(w_ext);
		if (h_ext == '0)
			h_eff = DW'(1);
		else if (h_ext > EW'(MAX_SPRITE_DIM))
			h_eff = DW'(MAX_SPRITE_DIM);
		else
			h_eff = DW'(h_ext);
	end

	// angle modulo 360, cosine taken as sine of angle plus 90
	always_comb begin
		ang_r = 11'(rotation_q);
		if (ang_r < 0)
			ang_r = ang_r + 11'sd360;
		if (ang_r < 0)
			ang_r = ang_r + 11'sd360;
		if (ang_r >= 11'sd360)
			ang_r = ang_r - 11'sd360;
		ang_s = ang_r[8:0];
		ang_c_sum = {1'b0, ang_s} + 10'd90;
		if (ang_c_sum >= 10'd360)
			ang_c_sum = ang_c_sum - 10'd360;
		ang_c = ang_c_sum[8:0];
	end

	always_comb begin
		case (pivot_q)
			smrb_pkg::PIV_CENTRE: begin
				mx_d = w_eff >> 1;
				my_d = h_eff >> 1;
			end
			smrb_pkg::PIV_CENTRE_LEFT: begin
				mx_d = '0;
				my_d = h_eff >> 1;
			end
			smrb_pkg::PIV_CENTRE_RIGHT: begin
				mx_d = w_eff;
				my_d = h_eff >> 1;
			end
			smrb_pkg::PIV_TOP_CENTRE: begin
				mx_d = w_eff >> 1;
				my_d = h_eff;
			end
			smrb_pkg::PIV_BOTTOM_CENTRE: begin
				mx_d = w_eff >> 1;
				my_d = '0;
			end
			smrb_pkg::PIV_TOP_LEFT: begin
				mx_d = '0;
				my_d = h_eff;
			end
			smrb_pkg::PIV_TOP_RIGHT: begin
				mx_d = w_eff;
				my_d = h_eff;
			end
			default: begin
				mx_d = '0;
				my_d = '0;
			end
		endcase
		w_s  = $signed(KW'(w_eff));
		mx_s = $signed(KW'(mx_d));
		my_s = $signed(KW'(my_d));
		x0   = KW'(anchor_x_q) - $signed(KW'(w_eff >> 1));
	end

	// refreshed every cycle from the configuration registers
	always_ff @(posedge clk) begin
		trig_q.rot_zero <= (rotation_q == '0);
		trig_q.mirror   <= mirror_q;
		trig_q.sin_v    <= smrb_pkg::sine_deg(ang_s);
		trig_q.cos_v    <= smrb_pkg::sine_deg(ang_c);
		mx_q            <= mx_d;
		my_q            <= my_d;
		kx_q            <= mirror_q ? (x0 + w_s - mx_s) : (x0 + mx_s);
		ky_q            <= KW'(anchor_y_q) - my_s;
		nx_q            <= mirror_q ? (x0 + w_s) : x0;
		ay_q            <= KW'(anchor_y_q);
	end

endmodule

// ===== rtl/core/smrb_front.sv =====
// ----------------------------------------------------------------------------
// smrb_front - pixel intake
// Accepts source pixels, tracks column and row in the sprite and tags each
// pixel as opaque and as last of the sprite before it enters the queue.
// ----------------------------------------------------------------------------
module smrb_front #(
	parameter int MAX_SPRITE_DIM = 256,
	localparam int DW = $clog2(MAX_SPRITE_DIM + 1),
	localparam int CW = $clog2(MAX_SPRITE_DIM)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [smrb_pkg::PIX_W-1:0]   s_tdata,
	input  logic                         cfg_valid,
	input  logic                         q_full,
	input  logic [DW-1:0]                w_eff,
	input  logic [DW-1:0]                h_eff,
	output logic                         push,
	output logic [CW-1:0]                col,
	output logic [CW-1:0]                row,
	output smrb_pkg::item_flags_t        flags,
	output logic [smrb_pkg::PIX_W-1:0]   pix
);

	logic [CW-1:0] col_q, row_q;
	logic [DW-1:0] col_inc, row_inc;
	logic          last_col, last_row;

	// a pending register write goes first
	assign s_tready = !q_full && !cfg_valid;
	assign push     = s_tvalid && s_tready;

	assign col_inc  = DW'(col_q) + DW'(1);
	assign row_inc  = DW'(row_q) + DW'(1);
	assign last_col = col_inc >= w_eff;
	assign last_row = row_inc >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[CW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	assign col          = col_q;
	assign row          = row_q;
	assign pix          = s_tdata;
	assign flags.opaque = (s_tdata[smrb_pkg::PIX_W-1 -: 8] != 8'd0);
	assign flags.done   = last_col && last_row;

endmodule

// ===== rtl/core/smrb_queue.sv =====
// ----------------------------------------------------------------------------
// smrb_queue - short queue between intake and geometry pipeline
// First-in first-out buffer of classified pixels.
// ----------------------------------------------------------------------------
module smrb_queue #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 4,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = (count_q == (PTR_W + 1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid)
		else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone write");
`endif

endmodule

// ===== rtl/core/smrb_back.sv =====
// ----------------------------------------------------------------------------
// smrb_back - geometry pipeline and output register
// Rotates or places each pixel, truncates toward zero, tests the visible area
// and forms the frame-buffer write. All stages advance together.
// ----------------------------------------------------------------------------
module smrb_back #(
	parameter int MAX_SPRITE_DIM = 256,
	parameter int FRAME_STRIDE   = 512,
	parameter int VISIBLE_WIDTH  = 480,
	parameter int VISIBLE_HEIGHT = 272,
	localparam int DW  = $clog2(MAX_SPRITE_DIM + 1),
	localparam int CW  = $clog2(MAX_SPRITE_DIM),
	localparam int KW  = smrb_pkg::geo_w(DW)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 pop,
	input  logic [CW-1:0]                        col,
	input  logic [CW-1:0]                        row,
	input  smrb_pkg::item_flags_t                flags,
	input  logic [smrb_pkg::PIX_W-1:0]           pix,
	input  smrb_pkg::trig_t                      trig,
	input  logic [DW-1:0]                        mx,
	input  logic [DW-1:0]                        my,
	input  logic signed [KW-1:0]                 kx,
	input  logic signed [KW-1:0]                 ky,
	input  logic signed [KW-1:0]                 nx,
	input  logic signed [KW-1:0]                 ay,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [smrb_pkg::TDATA_OUT_W-1:0]     m_tdata,
	output logic                                 m_tuser,
	output logic                                 m_tlast
);

	localparam int DXW  = DW + 1;
	localparam int PW   = DXW + smrb_pkg::SIN_W;
	localparam int NW   = KW + 15;
	localparam int SW   = NW - smrb_pkg::Q_FRAC;
	localparam int XW   = $clog2(VISIBLE_WIDTH);
	localparam int YW   = $clog2(VISIBLE_HEIGHT);
	localparam int SBW  = $clog2(FRAME_STRIDE + 1);
	localparam int LW   = (YW + SBW + 1 > smrb_pkg::ADDR_W) ? YW + SBW + 1 : smrb_pkg::ADDR_W;
	localparam int PADW = smrb_pkg::TDATA_OUT_W - smrb_pkg::ADDR_W - smrb_pkg::PIX_W;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [DXW-1:0]          dx_s1, dy_s1;
	logic signed [KW-1:0]           sxn_s1, syn_s1, sxn_s2, syn_s2, sxn_s3, syn_s3;
	logic [smrb_pkg::PIX_W-1:0]     pix_s1, pix_s2, pix_s3, pix_s4;
	smrb_pkg::item_flags_t          flags_s1, flags_s2, flags_s3;
	logic                           done_s4;

	logic signed [PW-1:0]           dxc_s2, dys_s2, dxs_s2, dyc_s2;
	logic signed [NW-1:0]           p_sum, xn_s3, yn_s3;

	logic signed [SW-1:0]           xq, yq, sx, sy;
	logic                           in_x, in_y;
	logic                           we_s4;
	logic [XW-1:0]                  sx_s4;
	logic [YW-1:0]                  sy_s4;

	logic [LW-1:0]                  addr_full;

	logic                           valid_q, we_q, done_q;
	logic [smrb_pkg::ADDR_W-1:0]    addr_q;
	logic [smrb_pkg::PIX_W-1:0]     color_q;

	assign en  = !valid_q || m_tready;
	assign pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= q_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	// s1: offsets from the pivot, plain placement for the unrotated case
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= DXW'(col) - DXW'(mx);
			dy_s1    <= DXW'(row) - DXW'(my);
			sxn_s1   <= trig.mirror ? (nx - KW'(col)) : (nx + KW'(col));
			syn_s1   <= ay - KW'(row);
			pix_s1   <= pix;
			flags_s1 <= flags;
		end
	end

	// s2: the four products
	always_ff @(posedge clk) begin
		if (en) begin
			dxc_s2   <= PW'(dx_s1) * PW'($signed(trig.cos_v));
			dys_s2   <= PW'(dy_s1) * PW'($signed(trig.sin_v));
			dxs_s2   <= PW'(dx_s1) * PW'($signed(trig.sin_v));
			dyc_s2   <= PW'(dy_s1) * PW'($signed(trig.cos_v));
			sxn_s2   <= sxn_s1;
			syn_s2   <= syn_s1;
			pix_s2   <= pix_s1;
			flags_s2 <= flags_s1;
		end
	end

	// s3: fixed-point numerators of screen x and y
	assign p_sum = NW'(dxc_s2) + NW'(dys_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s3    <= (NW'(kx) <<< smrb_pkg::Q_FRAC) + (trig.mirror ? -p_sum : p_sum);
			yn_s3    <= (NW'(ky) <<< smrb_pkg::Q_FRAC) + NW'(dxs_s2) - NW'(dyc_s2);
			sxn_s3   <= sxn_s2;
			syn_s3   <= syn_s2;
			pix_s3   <= pix_s2;
			flags_s3 <= flags_s2;
		end
	end

	// s4: truncate toward zero, pick path, test the visible area
	always_comb begin
		xq = SW'(xn_s3 >>> smrb_pkg::Q_FRAC)
			+ SW'(xn_s3[NW-1] && (xn_s3[smrb_pkg::Q_FRAC-1:0] != '0));
		yq = SW'(yn_s3 >>> smrb_pkg::Q_FRAC)
			+ SW'(yn_s3[NW-1] && (yn_s3[smrb_pkg::Q_FRAC-1:0] != '0));
		sx = trig.rot_zero ? SW'(sxn_s3) : xq;
		sy = trig.rot_zero ? SW'(syn_s3) : yq;
		in_x = !sx[SW-1] && (sx < SW'(VISIBLE_WIDTH));
		in_y = !sy[SW-1] && (sy < SW'(VISIBLE_HEIGHT));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			we_s4   <= flags_s3.opaque && in_x && in_y;
			sx_s4   <= sx[XW-1:0];
			sy_s4   <= sy[YW-1:0];
			pix_s4  <= pix_s3;
			done_s4 <= flags_s3.done;
		end
	end

	// output register: frame-buffer address
	assign addr_full = LW'(sx_s4) + LW'(sy_s4) * LW'(FRAME_STRIDE);

	always_ff @(posedge clk) begin
		if (en) begin
			we_q    <= we_s4;
			addr_q  <= we_s4 ? addr_full[smrb_pkg::ADDR_W-1:0] : '0;
			color_q <= we_s4 ? pix_s4 : '0;
			done_q  <= done_s4;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {PADW'(0), color_q, addr_q};
	assign m_tuser  = we_q;
	assign m_tlast  = done_q;

`ifndef SYNTHESIS
	a_idle_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("suppressed write carries a non-zero payload");
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline moved while the output was stalled");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && en |=> m_tvalid)
		else $error("last stage result lost on its way out");
	a_pop_gated: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped pixel did not enter the pipeline");
`endif

endmodule

// ===== rtl/core/sprite_rotate_mirror_blitter.sv =====
// ----------------------------------------------------------------------------
// sprite_rotate_mirror_blitter - sprite blitter with rotation and alpha transparency
// Turns a row-major stream of ARGB sprite pixels into frame-buffer writes,
// optionally rotated about a pivot and mirrored, skipping transparent pixels.
//
//  channel  direction  fields
//  s_*      in         tdata: source_pixel
//  m_*      out        tdata: write_address, write_color; tuser: write_enable;
//                      tlast: sprite_done
//  cfg_*    in         cfg_index selects the register, cfg_data the value
//
// One pixel per cycle sustained while m_tready is high and no register write is
// pending; each result passes the queue, the geometry stages and the output register.
// A four-entry queue decouples intake from the pipeline, so input keeps
// flowing for up to four pixels while the output is stalled.
// Reset clears counters, pipeline valids and registers to their reset values.
// A pending register write holds off pixel intake for that cycle.
// ----------------------------------------------------------------------------
module sprite_rotate_mirror_blitter #(
	parameter int MAX_SPRITE_DIM = 256,
	parameter int FRAME_STRIDE   = 512,
	parameter int VISIBLE_WIDTH  = 480,
	parameter int VISIBLE_HEIGHT = 272
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [smrb_pkg::PIX_W-1:0]           s_tdata,   // [31:0] source_pixel
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [smrb_pkg::TDATA_OUT_W-1:0]     m_tdata,   // [17:0] write_address,
	                                                        // [49:18] write_color, rest zero
	output logic                                 m_tuser,   // [0] write_enable
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [smrb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smrb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DW = $clog2(MAX_SPRITE_DIM + 1);
	localparam int CW = $clog2(MAX_SPRITE_DIM);
	localparam int KW = smrb_pkg::geo_w(DW);
	localparam int IW = smrb_pkg::PIX_W + 2 + 2 * CW;

	logic [DW-1:0]              w_eff, h_eff, mx, my;
	smrb_pkg::trig_t            trig;
	logic signed [KW-1:0]       kx, ky, nx, ay;

	logic                       push, q_full, q_valid, pop;
	logic [CW-1:0]              f_col, f_row, b_col, b_row;
	smrb_pkg::item_flags_t      f_flags, b_flags;
	logic [smrb_pkg::PIX_W-1:0] f_pix, b_pix;
	logic [IW-1:0]              wr_item, rd_item;

	smrb_cfg #(
		.MAX_SPRITE_DIM(MAX_SPRITE_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.trig_q    (trig),
		.mx_q      (mx),
		.my_q      (my),
		.kx_q      (kx),
		.ky_q      (ky),
		.nx_q      (nx),
		.ay_q      (ay)
	);

	smrb_front #(
		.MAX_SPRITE_DIM(MAX_SPRITE_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.q_full    (q_full),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.push      (push),
		.col       (f_col),
		.row       (f_row),
		.flags     (f_flags),
		.pix       (f_pix)
	);

	assign wr_item = {f_row, f_col, f_flags, f_pix};
	assign {b_row, b_col, b_flags, b_pix} = rd_item;

	smrb_queue #(
		.WIDTH (IW),
		.DEPTH (4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (wr_item),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_data  (rd_item)
	);

	smrb_back #(
		.MAX_SPRITE_DIM (MAX_SPRITE_DIM),
		.FRAME_STRIDE   (FRAME_STRIDE),
		.VISIBLE_WIDTH  (VISIBLE_WIDTH),
		.VISIBLE_HEIGHT (VISIBLE_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.pop      (pop),
		.col      (b_col),
		.row      (b_row),
		.flags    (b_flags),
		.pix      (b_pix),
		.trig     (trig),
		.mx       (mx),
		.my       (my),
		.kx       (kx),
		.ky       (ky),
		.nx       (nx),
		.ay       (ay),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
